>>> design/iprm_pkg.sv
// Shared types, widths and helpers for the IP prefix rule matcher.
// No dependencies; used by iprm_cell and ip_prefix_rule_matcher_unit.
`timescale 1ns / 1ps
`default_nettype none

package iprm_pkg;

  localparam int unsigned DefaultMaxRules = 64;
  localparam int unsigned AddrW           = 128;
  localparam int unsigned HalfW           = 64;
  localparam int unsigned LenW            = 8;
  localparam int unsigned MaskW           = 64;
  localparam int unsigned NumberW         = 6;
  localparam int unsigned CountW          = 7;
  localparam logic [LenW-1:0] FullLength  = 8'd128;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_MATCH  = 1'b1
  } op_t;

  // One item as it travels down the chain of cells
  typedef struct packed {
    op_t               op;
    logic [AddrW-1:0]  addr;
    logic [LenW-1:0]   len;
    logic [MaskW-1:0]  allowed;
    logic [MaskW-1:0]  mask;
    logic [CountW-1:0] count;
    logic              full;
  } item_t;

  // Leading-bits mask for a prefix length of 0..128
  function automatic logic [AddrW-1:0] lead_mask(input logic [LenW-1:0] len);
    logic [AddrW-1:0] m;
    for (int j = 0; j < AddrW; j++) begin
      m[j] = ((AddrW - 1 - j) < int'(len));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> design/iprm_cell.sv
// One cell of the rule chain: holds a single prefix rule and one stage of the item.
// Depends on iprm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iprm_cell #(
  parameter int unsigned CELL_INDEX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             prev_valid,
  input  wire iprm_pkg::item_t  prev_item,
  output logic                  next_valid,
  output iprm_pkg::item_t       next_item
);
  import iprm_pkg::*;

  localparam logic [CountW-1:0] Index = CountW'(CELL_INDEX);

  logic [AddrW-1:0] rule_prefix;
  logic [LenW-1:0]  rule_length;
  logic             hit;
  logic             store;
  item_t            item_next;

  // Compare the address against this cell's rule, stored prefix is pre-masked
  always_comb begin
    hit = (prev_item.op == OP_MATCH) && prev_item.allowed[CELL_INDEX] &&
          (Index < prev_item.count) &&
          ((prev_item.addr & lead_mask(rule_length)) == rule_prefix);
    store = prev_valid && (prev_item.op == OP_INSERT) && !prev_item.full &&
            (prev_item.count == Index);
    item_next = prev_item;
    item_next.mask[CELL_INDEX] = hit;
  end

  // Write the rule when an insert is aimed at this cell
  always_ff @(posedge clk) begin
    if (en && store) begin
      rule_prefix <= prev_item.addr;
      rule_length <= prev_item.len;
    end
  end

  // Hand the item on to the neighbour
  always_ff @(posedge clk) begin
    if (rst) begin
      next_valid <= 1'b0;
    end else if (en) begin
      next_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      next_item <= item_next;
    end
  end

endmodule

`default_nettype wire

>>> design/ip_prefix_rule_matcher_unit.sv
// Top level of the IP prefix rule matcher: entry logic, chain of rule cells, output register.
// Depends on iprm_pkg and iprm_cell.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------------------
//   input    | in_valid / in_ready | operation, address_high, address_low, prefix_length,
//            |                     | allowed_rules
//   output   | out_valid/out_ready | match_mask, rule_number, table_full
//
// An item walks the chain of MAX_RULES cells, one cell per cycle while the chain is not
// frozen; each cell holds one rule. One item is in the chain at a time, so a new item is
// taken once the previous one has left the chain, while its result may still wait in the
// output register.
// Reset clears the rule count and all valid flags; stored rules are not cleared.
// A finished item that meets a waiting result freezes the chain until that result is taken.
`timescale 1ns / 1ps
`default_nettype none

module ip_prefix_rule_matcher_unit #(
  parameter int unsigned MAX_RULES = iprm_pkg::DefaultMaxRules
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          operation,
  input  wire logic [iprm_pkg::HalfW-1:0]    address_high,
  input  wire logic [iprm_pkg::HalfW-1:0]    address_low,
  input  wire logic [iprm_pkg::LenW-1:0]     prefix_length,
  input  wire logic [iprm_pkg::MaskW-1:0]    allowed_rules,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [iprm_pkg::MaskW-1:0]         match_mask,
  output logic [iprm_pkg::NumberW-1:0]       rule_number,
  output logic                               table_full
);
  import iprm_pkg::*;

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_RULES);

  logic              stage_valid [MAX_RULES+1];
  item_t             stage_item  [MAX_RULES+1];
  logic [CountW-1:0] rule_count;
  logic              busy;
  logic              accept;
  logic              en;
  logic              drain;
  logic [LenW-1:0]   len_sat;
  logic              is_full;
  item_t             entry;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  // Stall the chain only while a finished item cannot leave it
  assign en    = !stage_valid[MAX_RULES] || !out_valid || out_ready;
  assign drain = stage_valid[MAX_RULES] && en;

  // Build the entry item: saturate the length, mask the prefix of an insert, tag the target slot
  always_comb begin
    len_sat       = (prefix_length > FullLength) ? FullLength : prefix_length;
    is_full       = (rule_count >= MaxCount);
    entry.op      = op_t'(operation);
    entry.len     = len_sat;
    entry.allowed = allowed_rules;
    entry.mask    = '0;
    entry.count   = rule_count;
    entry.full    = (operation == OP_INSERT) && is_full;
    if (operation == OP_INSERT) begin
      entry.addr = {address_high, address_low} & lead_mask(len_sat);
    end else begin
      entry.addr = {address_high, address_low};
    end
  end

  assign stage_valid[0] = accept;
  assign stage_item[0]  = entry;

  // Row of rule cells
  for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
    iprm_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (stage_valid[g]),
      .prev_item  (stage_item[g]),
      .next_valid (stage_valid[g+1]),
      .next_item  (stage_item[g+1])
    );
  end

  // Track the rule count and the single item in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
      busy       <= 1'b0;
    end else begin
      if (accept && (operation == OP_INSERT) && !is_full) begin
        rule_count <= rule_count + CountW'(1);
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (drain) begin
        busy <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      table_full <= stage_item[MAX_RULES].full;
      if (stage_item[MAX_RULES].op == OP_MATCH) begin
        match_mask  <= stage_item[MAX_RULES].mask;
        rule_number <= '0;
      end else begin
        match_mask  <= '0;
        rule_number <= stage_item[MAX_RULES].full ? '0
                                                  : stage_item[MAX_RULES].count[NumberW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> dv/ip_prefix_rule_matcher_unit_tb.sv
// Self-checking testbench for ip_prefix_rule_matcher_unit: a directed table, then random
// inserts and matches with idle/stall phases, each result checked against a rule-table model or the row's own fields.
// Depends on iprm_pkg and the design sources only.
`timescale 1ns / 1ps

module ip_prefix_rule_matcher_unit_tb;
  import iprm_pkg::*;

  localparam int MaxRules     = DefaultMaxRules;
  localparam int RandomItems  = 1200;
  localparam int WatchdogMax  = 4000;
  localparam logic [HalfW-1:0] Ones64 = {HalfW{1'b1}};

  // One stimulus row; the expected fields count only where typed is set
  typedef struct packed {
    op_t              op;
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] lo;
    logic [LenW-1:0]  len;
    logic [MaskW-1:0] allowed;
    logic             typed;
    logic [MaskW-1:0] mask;
    logic [NumberW-1:0] number;
    logic             full;
  } stim_row_t;

  typedef struct packed {
    logic [MaskW-1:0]   mask;
    logic [NumberW-1:0] number;
    logic               full;
  } rule_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                operation = 1'b0;
  logic [HalfW-1:0]    address_high = '0;
  logic [HalfW-1:0]    address_low = '0;
  logic [LenW-1:0]     prefix_length = '0;
  logic [MaskW-1:0]    allowed_rules = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [MaskW-1:0]    match_mask;
  logic [NumberW-1:0]  rule_number;
  logic                table_full;

  // Model of the rule table
  logic [AddrW-1:0]    known_prefix [MaxRules];
  logic [LenW-1:0]     known_len [MaxRules];
  int                  known_count = 0;

  rule_result_t        expected_results [$];
  stim_row_t           directed_plan [$];
  int                  error_count = 0;
  int                  idle_cycles = 0;
  int                  sender_idle_pct = 0;
  int                  stall_pct = 0;

  ip_prefix_rule_matcher_unit #(
    .MAX_RULES(MaxRules)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .address_high (address_high),
    .address_low  (address_low),
    .prefix_length(prefix_length),
    .allowed_rules(allowed_rules),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .match_mask   (match_mask),
    .rule_number  (rule_number),
    .table_full   (table_full)
  );

  always #5 clk = ~clk;

  function automatic logic [AddrW-1:0] leading_bits(input logic [LenW-1:0] len);
    if (len == '0) return '0;
    return {AddrW{1'b1}} << (AddrW - int'(len));
  endfunction

  function automatic logic [HalfW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Apply one accepted item to the rule table and return its result
  function automatic rule_result_t rule_table_response(input stim_row_t row);
    rule_result_t     res;
    logic [LenW-1:0]  len;
    logic [AddrW-1:0] addr;
    res = '0;
    addr = {row.hi, row.lo};
    if (row.op == OP_INSERT) begin
      len = (row.len > FullLength) ? FullLength : row.len;
      if (known_count >= MaxRules) begin
        res.full = 1'b1;
      end else begin
        known_prefix[known_count] = addr & leading_bits(len);
        known_len[known_count] = len;
        res.number = NumberW'(known_count);
        known_count++;
      end
    end else begin
      for (int r = 0; r < known_count; r++) begin
        if (row.allowed[r] && ((addr & leading_bits(known_len[r])) == known_prefix[r]))
          res.mask[r] = 1'b1;
      end
    end
    return res;
  endfunction

  // Build a random item; most matches aim at a stored prefix so that hits are common
  function automatic stim_row_t random_row(input bit fill_table);
    stim_row_t        row;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] keep;
    int               pick;
    int               r;
    int               idx;
    row = '0;
    row.hi = rand64();
    row.lo = rand64();
    row.len = LenW'($urandom_range(0, 255));
    row.allowed = rand64();
    pick = $urandom_range(0, 9);
    if (fill_table || $urandom_range(0, 9) == 0) begin
      row.op = OP_INSERT;
      if (pick < 6) begin
        row.len = LenW'($urandom_range(0, 128));
      end else if (pick < 8) begin
        row.len = LenW'($urandom_range(0, 32));
      end else if (pick == 8) begin
        row.len = LenW'($urandom_range(129, 255));
      end else if (known_count > 0) begin
        // repeat a stored prefix
        r = $urandom_range(0, known_count - 1);
        {row.hi, row.lo} = known_prefix[r];
        row.len = known_len[r];
      end
    end else begin
      row.op = OP_MATCH;
      if (pick < 6 && known_count > 0) begin
        r = $urandom_range(0, known_count - 1);
        keep = leading_bits(known_len[r]);
        addr = known_prefix[r] | ({row.hi, row.lo} & ~keep);
        // near miss: flip one bit inside the prefix
        if (pick == 0 && known_len[r] != '0) begin
          idx = AddrW - $urandom_range(1, int'(known_len[r]));
          addr[idx] = ~addr[idx];
        end
        {row.hi, row.lo} = addr;
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        row.allowed = Ones64;
      end else if (pick < 7 && known_count > 0) begin
        row.allowed = ~(64'd1 << $urandom_range(0, known_count - 1));
      end else if (pick == 7) begin
        row.allowed = '0;
      end
    end
    return row;
  endfunction

  // Offer one item, hold it until taken, then queue its expected result
  task automatic offer_item(input stim_row_t row);
    rule_result_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= row.op;
    address_high  <= row.hi;
    address_low   <= row.lo;
    prefix_length <= row.len;
    allowed_rules <= row.allowed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = rule_table_response(row);
    if (row.typed) begin
      predicted.mask = row.mask;
      predicted.number = row.number;
      predicted.full = row.full;
    end
    expected_results.push_back(predicted);
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: unexpected item: mask %h number %0d full %0d",
                   $time, match_mask, rule_number, table_full);
      end else begin
        if (match_mask !== expected_results[0].mask ||
            rule_number !== expected_results[0].number ||
            table_full !== expected_results[0].full) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: mismatch: mask exp %h got %h, number exp %0d got %0d, full exp %0d got %0d",
                     $time, expected_results[0].mask, match_mask,
                     expected_results[0].number, rule_number,
                     expected_results[0].full, table_full);
        end
        void'(expected_results.pop_front());
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogMax) begin
        $display("ip_prefix_rule_matcher_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    // empty table, then inserts of every length class, then matches mixed with two more inserts
    directed_plan.push_back('{OP_MATCH, Ones64, Ones64, 8'd0, Ones64, 1'b1, 64'd0, 6'd0, 1'b0});
    directed_plan.push_back('{OP_INSERT, Ones64, Ones64, 8'd0, 64'd0, 1'b1, 64'd0, 6'd0, 1'b0});
    directed_plan.push_back('{OP_INSERT, Ones64, Ones64, 8'd128, Ones64, 1'b1, 64'd0, 6'd1,
                              1'b0});
    directed_plan.push_back('{OP_INSERT, 64'h2001_0db8_0000_0000, 64'hdead_beef_0bad_f00d,
                              8'd255, 64'd0, 1'b1, 64'd0, 6'd2, 1'b0});
    directed_plan.push_back('{OP_INSERT, 64'h2001_0db8_ffff_ffff, Ones64, 8'd64, 64'd0,
                              1'b1, 64'd0, 6'd3, 1'b0});
    directed_plan.push_back('{OP_INSERT, 64'h0a12_3456_789a_bcde, 64'h1234_5678_9abc_def0,
                              8'd8, 64'd0, 1'b1, 64'd0, 6'd4, 1'b0});
    directed_plan.push_back('{OP_INSERT, 64'h8000_0000_0000_0000, 64'd0, 8'd1, 64'd0, 1'b1,
                              64'd0, 6'd5, 1'b0});
    directed_plan.push_back('{OP_INSERT, 64'd0, 64'd1, 8'd127, 64'd0, 1'b1, 64'd0, 6'd6, 1'b0});
    directed_plan.push_back('{OP_INSERT, Ones64, 64'h8000_0000_0000_0000, 8'd65, 64'd0, 1'b1,
                              64'd0, 6'd7, 1'b0});
    directed_plan.push_back('{OP_MATCH, Ones64, Ones64, 8'd0, Ones64, 1'b0, 64'd0, 6'd0, 1'b0});
    directed_plan.push_back('{OP_MATCH, Ones64, Ones64, 8'd0, 64'd0, 1'b1, 64'd0, 6'd0, 1'b0});
    directed_plan.push_back('{OP_MATCH, Ones64, Ones64, 8'd0, 64'hffff_ffff_ffff_ff00, 1'b1,
                              64'd0, 6'd0, 1'b0});
    directed_plan.push_back('{OP_MATCH, 64'd0, 64'd0, 8'd0, Ones64, 1'b0, 64'd0, 6'd0, 1'b0});
    directed_plan.push_back('{OP_MATCH, 64'h0a01_0203_0000_0000, 64'd0, 8'd0, Ones64, 1'b0,
                              64'd0, 6'd0, 1'b0});
    directed_plan.push_back('{OP_MATCH, 64'h2001_0db8_0000_0000, 64'hdead_beef_0bad_f00d,
                              8'd0, Ones64, 1'b0, 64'd0, 6'd0, 1'b0});
    directed_plan.push_back('{OP_MATCH, 64'h2001_0db8_ffff_ffff, 64'd0, 8'd0, Ones64, 1'b0,
                              64'd0, 6'd0, 1'b0});
    directed_plan.push_back('{OP_INSERT, 64'h0a00_0000_0000_0000, 64'd0, 8'd8, 64'd0, 1'b1,
                              64'd0, 6'd8, 1'b0});
    directed_plan.push_back('{OP_MATCH, 64'h0ac8_0101_0000_0000, 64'd0, 8'd0, Ones64, 1'b0,
                              64'd0, 6'd0, 1'b0});
    directed_plan.push_back('{OP_MATCH, 64'h0ac8_0101_0000_0000, 64'd0, 8'd0, ~64'h10, 1'b0,
                              64'd0, 6'd0, 1'b0});
    directed_plan.push_back('{OP_INSERT, 64'h5a5a_a5a5_3c3c_c3c3, Ones64, 8'd63, 64'd0, 1'b1,
                              64'd0, 6'd9, 1'b0});
    directed_plan.push_back('{OP_MATCH, Ones64, Ones64, 8'd200, Ones64, 1'b0, 64'd0, 6'd0,
                              1'b0});

    // hold reset, then walk the directed table
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_plan[i]) offer_item(directed_plan[i]);

    // random items in four idling phases; the second half fills the table
    for (int n = 0; n < RandomItems; n++) begin
      case (n * 4 / RandomItems)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 61; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 61; end
        default: begin sender_idle_pct = 14; stall_pct = 14; end
      endcase
      offer_item(random_row(n >= RandomItems / 2 && known_count < MaxRules));
    end
    in_valid <= 1'b0;

    // drain, then allow one more pass through the chain
    while (expected_results.size() != 0) @(posedge clk);
    repeat (MaxRules + 8) @(posedge clk);
    if (expected_results.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("ip_prefix_rule_matcher_unit test passed");
    end else begin
      $display("ip_prefix_rule_matcher_unit test failed");
    end
    $finish;
  end

endmodule

>>> ip_prefix_rule_matcher_unit.f
design/iprm_pkg.sv
design/iprm_cell.sv
design/ip_prefix_rule_matcher_unit.sv
dv/ip_prefix_rule_matcher_unit_tb.sv
